@@ rtl/lprp_pkg.sv @@
`timescale 1ns / 1ps

package lprp_pkg;

    // Field types
    typedef struct packed {
        logic signed [19:0] x_mm;
        logic signed [19:0] y_mm;
        logic signed [19:0] z_mm;
    } point_t;

    typedef struct packed {
        logic [9:0]  column;
        logic [5:0]  row;
        logic [15:0] range_cm;
    } pixel_t;

    // Image size defaults
    localparam int IMAGE_WIDTH_DEFAULT  = 1024;
    localparam int IMAGE_HEIGHT_DEFAULT = 64;

    // Register indexes
    localparam logic REG_MIN_ELEVATION = 1'b0;
    localparam logic REG_MAX_ELEVATION = 1'b1;

    localparam logic signed [15:0] MIN_ELEVATION_RESET = -16'sd4289;
    localparam logic signed [15:0] MAX_ELEVATION_RESET = 16'sd4289;

    // Angle formats: output angles in 2^-14 rad, CORDIC accumulator in 2^-16 rad
    localparam int ANG_W        = 17;
    localparam int ANG_PI       = 51472;
    localparam int ANG_HALF_PI  = 25736;
    localparam int ACC_W        = 19;
    localparam int FINE_HALF_PI = 102944;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        19'sd51472, 19'sd30386, 19'sd16055, 19'sd8150,
        19'sd4091,  19'sd2047,  19'sd1024,  19'sd512,
        19'sd256,   19'sd128,   19'sd64,    19'sd32,
        19'sd16,    19'sd8,     19'sd4,     19'sd2
    };

    // Root width: radicand is 56 bits (horizontal sum of squares << 16)
    localparam int SQRT_N = 28;

    // floor(s / 10) = (s * DIV10_M) >> DIV10_K, exact for s < 2^20
    localparam logic [19:0] DIV10_M = 20'd838861;
    localparam int          DIV10_K = 23;

endpackage

@@ rtl/lprp_sqrt_pipe.sv @@
`timescale 1ns / 1ps

// Integer square root, one root bit per stage.
module lprp_sqrt_pipe #(
    parameter int N     = lprp_pkg::SQRT_N,
    parameter int TAG_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2*N-1:0]     radicand,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [N-1:0]       root,
    output logic [TAG_W-1:0]   out_tag
);

    logic             vld_reg  [N];
    logic [N-1:0]     root_reg [N];
    logic [N+1:0]     rem_reg  [N];
    logic [2*N-1:0]   rad_reg  [N];
    logic [TAG_W-1:0] tag_reg  [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic             vld_in;
        logic [N-1:0]     root_in;
        logic [N+1:0]     rem_in;
        logic [2*N-1:0]   rad_in;
        logic [TAG_W-1:0] tag_in;
        logic [N+1:0]     cand;
        logic [N+1:0]     trial;
        logic             take;

        if (j == 0) begin : g_first
            assign vld_in  = in_valid;
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = radicand;
            assign tag_in  = in_tag;
        end else begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign tag_in  = tag_reg[j-1];
        end

        // remainder stays below 2^N before the next pair is brought down
        assign cand  = {rem_in[N-1:0], rad_in[2*N-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign take  = (cand >= trial);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[j] <= 1'b0;
            end else begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            root_reg[j] <= (root_in << 1) | N'(take);
            rem_reg[j]  <= take ? (cand - trial) : cand;
            rad_reg[j]  <= rad_in << 2;
            tag_reg[j]  <= tag_in;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

@@ rtl/lprp_cordic_pipe.sv @@
`timescale 1ns / 1ps

// Vectoring CORDIC: angle of (re, im), quadrant fold, one rotation per stage,
// then rounding to 2^-14 rad and clamping to +-LIM.
module lprp_cordic_pipe #(
    parameter int W     = lprp_pkg::CORDIC_W,
    parameter int LIM   = lprp_pkg::ANG_PI,
    parameter int TAG_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [W-1:0]               re_in,
    input  logic signed [W-1:0]               im_in,
    input  logic [TAG_W-1:0]                  in_tag,
    output logic                              out_valid,
    output logic signed [lprp_pkg::ANG_W-1:0] angle,
    output logic [TAG_W-1:0]                  out_tag
);

    localparam int STEPS = lprp_pkg::CORDIC_STEPS;
    localparam int AW    = lprp_pkg::ACC_W;

    logic                vld_reg [STEPS+1];
    logic signed [W-1:0] re_reg  [STEPS+1];
    logic signed [W-1:0] im_reg  [STEPS+1];
    logic signed [AW-1:0] acc_reg [STEPS+1];
    logic [TAG_W-1:0]    tag_reg [STEPS+1];

    logic signed [W-1:0]  re0_next;
    logic signed [W-1:0]  im0_next;
    logic signed [AW-1:0] acc0_next;

    // fold the left half plane onto the right
    always_comb begin
        re0_next  = re_in;
        im0_next  = im_in;
        acc0_next = '0;
        if (re_in < 0) begin
            if (im_in >= 0) begin
                re0_next  = im_in;
                im0_next  = -re_in;
                acc0_next = AW'(lprp_pkg::FINE_HALF_PI);
            end else begin
                re0_next  = -im_in;
                im0_next  = re_in;
                acc0_next = -AW'(lprp_pkg::FINE_HALF_PI);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end else begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        re_reg[0]  <= re0_next;
        im_reg[0]  <= im0_next;
        acc_reg[0] <= acc0_next;
        tag_reg[0] <= in_tag;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [W-1:0] dre;
        logic signed [W-1:0] dim;

        assign dre = im_reg[i] >>> i;
        assign dim = re_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[i+1] <= 1'b0;
            end else begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk) begin
            if (im_reg[i] >= 0) begin
                re_reg[i+1]  <= re_reg[i] + dre;
                im_reg[i+1]  <= im_reg[i] - dim;
                acc_reg[i+1] <= acc_reg[i] + lprp_pkg::ATAN_TAB[i];
            end else begin
                re_reg[i+1]  <= re_reg[i] - dre;
                im_reg[i+1]  <= im_reg[i] + dim;
                acc_reg[i+1] <= acc_reg[i] - lprp_pkg::ATAN_TAB[i];
            end
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    // round half up to 2^-14, clamp
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] clamped;
    logic                 out_vld_reg;
    logic signed [lprp_pkg::ANG_W-1:0] angle_reg;
    logic [TAG_W-1:0]     out_tag_reg;

    always_comb begin
        rnd = (acc_reg[STEPS] + AW'(2)) >>> 2;
        if (rnd > AW'(LIM)) begin
            clamped = AW'(LIM);
        end else if (rnd < -AW'(LIM)) begin
            clamped = -AW'(LIM);
        end else begin
            clamped = rnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk) begin
        angle_reg   <= lprp_pkg::ANG_W'(clamped);
        out_tag_reg <= tag_reg[STEPS];
    end

    assign out_valid = out_vld_reg;
    assign angle     = angle_reg;
    assign out_tag   = out_tag_reg;

endmodule

@@ rtl/lprp_div_pipe.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage; quotient must fit QW bits.
module lprp_div_pipe #(
    parameter int QW    = 6,
    parameter int NW    = 29,
    parameter int DW    = 18,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NW-1:0]    dividend,
    input  logic [DW-1:0]    divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [QW-1:0]    quotient,
    output logic [TAG_W-1:0] out_tag
);

    localparam int EW = (NW > DW + QW) ? NW : DW + QW;

    logic             vld_reg [QW];
    logic [NW-1:0]    rem_reg [QW];
    logic [DW-1:0]    dvs_reg [QW];
    logic [QW-1:0]    q_reg   [QW];
    logic [TAG_W-1:0] tag_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic             vld_in;
        logic [NW-1:0]    rem_in;
        logic [DW-1:0]    dvs_in;
        logic [QW-1:0]    q_in;
        logic [TAG_W-1:0] tag_in;
        logic [EW-1:0]    dsh;
        logic [EW-1:0]    rem_ext;
        logic             take;

        if (j == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = dividend;
            assign dvs_in = divisor;
            assign q_in   = '0;
            assign tag_in = in_tag;
        end else begin : g_next
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign dvs_in = dvs_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        assign dsh     = EW'(dvs_in) << (QW - 1 - j);
        assign rem_ext = EW'(rem_in);
        assign take    = (rem_ext >= dsh);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[j] <= 1'b0;
            end else begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            rem_reg[j] <= take ? NW'(rem_ext - dsh) : rem_in;
            dvs_reg[j] <= dvs_in;
            q_reg[j]   <= (q_in << 1) | QW'(take);
            tag_reg[j] <= tag_in;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quotient  = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

@@ rtl/lidar_point_to_range_pixel.sv @@
`timescale 1ns / 1ps

// Channel     Signals                          Transaction
// ---------   ------------------------------   ----------------------------------
// point in    start, busy, point               start high, busy low at clk edge
// pixel out   result_valid, result             one-cycle strobe, no back-pressure
// config      cfg_we, cfg_index, cfg_data      cfg_we high at clk edge
//
// One point enters every cycle; busy is tied low. A pixel strobes once its
// point has passed the two 28-stage square-root pipes, the 18-stage CORDIC
// pair and the bit-per-stage row divider. Points at the origin or outside the
// elevation window produce no strobe. Reset (rst_n low, async) empties the pipe
// and loads the default elevation window. The receiver cannot stall, so every
// stage advances each cycle.
module lidar_point_to_range_pixel #(
    parameter int IMAGE_WIDTH  = lprp_pkg::IMAGE_WIDTH_DEFAULT,
    parameter int IMAGE_HEIGHT = lprp_pkg::IMAGE_HEIGHT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lprp_pkg::point_t  point,
    output logic              result_valid,
    output lprp_pkg::pixel_t  result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int N     = lprp_pkg::SQRT_N;
    localparam int CW    = lprp_pkg::CORDIC_W;
    localparam int AGW   = lprp_pkg::ANG_W;

    // column = floor(v / 102944), v = (az + pi) * (W-1) + pi, by reciprocal
    localparam int COL_D  = 2 * lprp_pkg::ANG_PI;
    localparam int COL_VW = $clog2(COL_D * (IMAGE_WIDTH - 1) + lprp_pkg::ANG_PI + 1);
    localparam int COL_K  = COL_VW + 17;
    localparam logic [63:0] COL_M =
        ((64'd1 << COL_K) + 64'(COL_D - 1)) / 64'(COL_D);
    localparam int COL_MW = COL_VW + 1;
    localparam int COL_QW = $clog2(IMAGE_WIDTH);

    // row = floor((2*num*(H-1) + den) / (2*den))
    localparam int NUM_W  = 17;
    localparam int ROW_MC = 2 * (IMAGE_HEIGHT - 1);
    localparam int MC_W   = $clog2(ROW_MC + 1);
    localparam int DVD_W  = NUM_W + MC_W + 1;
    localparam int DVS_W  = NUM_W + 1;
    localparam int ROW_QW = $clog2(IMAGE_HEIGHT);

    assign busy = 1'b0;

    // ---------------- configuration ----------------
    logic signed [15:0] min_el_reg;
    logic signed [15:0] max_el_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_el_reg <= lprp_pkg::MIN_ELEVATION_RESET;
            max_el_reg <= lprp_pkg::MAX_ELEVATION_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lprp_pkg::REG_MIN_ELEVATION: min_el_reg <= cfg_data;
                lprp_pkg::REG_MAX_ELEVATION: max_el_reg <= cfg_data;
            endcase
        end
    end

    // ---------------- capture ----------------
    logic             s0_vld_reg;
    lprp_pkg::point_t s0_pt_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_vld_reg <= 1'b0;
        end else begin
            s0_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        s0_pt_reg <= point;
    end

    // ---------------- squares ----------------
    logic signed [39:0] xx_full;
    logic signed [39:0] yy_full;
    logic signed [39:0] zz_full;
    logic               s1_vld_reg;
    logic [38:0]        xx_reg;
    logic [38:0]        yy_reg;
    logic [38:0]        zz_reg;
    lprp_pkg::point_t   s1_pt_reg;
    logic               s1_azz_reg;
    logic               s1_nz_reg;

    assign xx_full = 40'(s0_pt_reg.x_mm) * 40'(s0_pt_reg.x_mm);
    assign yy_full = 40'(s0_pt_reg.y_mm) * 40'(s0_pt_reg.y_mm);
    assign zz_full = 40'(s0_pt_reg.z_mm) * 40'(s0_pt_reg.z_mm);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        xx_reg     <= xx_full[38:0];
        yy_reg     <= yy_full[38:0];
        zz_reg     <= zz_full[38:0];
        s1_pt_reg  <= s0_pt_reg;
        // on the z axis line through the origin the azimuth is taken as zero
        s1_azz_reg <= (s0_pt_reg.x_mm == '0) && (s0_pt_reg.y_mm == '0);
        s1_nz_reg  <= (s0_pt_reg != '0);
    end

    // ---------------- sums ----------------
    logic             s2_vld_reg;
    logic [39:0]      hs_reg;
    logic [39:0]      r2_reg;
    lprp_pkg::point_t s2_pt_reg;
    logic             s2_azz_reg;
    logic             s2_nz_reg;
    logic [39:0]      hs_next;

    assign hs_next = 40'(xx_reg) + 40'(yy_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_vld_reg <= 1'b0;
        end else begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        hs_reg     <= hs_next;
        r2_reg     <= hs_next + 40'(zz_reg);
        s2_pt_reg  <= s1_pt_reg;
        s2_azz_reg <= s1_azz_reg;
        s2_nz_reg  <= s1_nz_reg;
    end

    // ---------------- square roots ----------------
    // h = isqrt(hs << 16) feeds the elevation CORDIC; isqrt(r2) gives the range
    localparam int SQ_TAG_W = 1 + $bits(lprp_pkg::point_t);

    logic                sq_vld;
    logic [N-1:0]        h_root;
    logic [SQ_TAG_W-1:0] sq_tag;
    logic                sqr_vld;
    logic [N-1:0]        r_root;
    logic                sqr_nz;

    lprp_sqrt_pipe #(
        .N     (N),
        .TAG_W (SQ_TAG_W)
    ) u_sqrt_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .radicand  ({hs_reg, 16'b0}),
        .in_tag    ({s2_azz_reg, s2_pt_reg}),
        .out_valid (sq_vld),
        .root      (h_root),
        .out_tag   (sq_tag)
    );

    lprp_sqrt_pipe #(
        .N     (N),
        .TAG_W (1)
    ) u_sqrt_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .radicand  ({16'b0, r2_reg}),
        .in_tag    (s2_nz_reg),
        .out_valid (sqr_vld),
        .root      (r_root),
        .out_tag   (sqr_nz)
    );

    // ---------------- range scale, CORDIC operands ----------------
    // floor(isqrt(r2) / 10) equals isqrt(floor(r2 / 100))
    logic             s3_vld_reg;
    logic [39:0]      rmul_reg;
    logic [N-1:0]     s3_h_reg;
    lprp_pkg::point_t s3_pt_reg;
    logic             s3_azz_reg;
    logic             s3_nz_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s3_vld_reg <= 1'b0;
        end else begin
            s3_vld_reg <= sq_vld && sqr_vld;
        end
    end

    always_ff @(posedge clk) begin
        rmul_reg   <= 40'(r_root[19:0]) * 40'(lprp_pkg::DIV10_M);
        s3_h_reg   <= h_root;
        s3_pt_reg  <= sq_tag[SQ_TAG_W-2:0];
        s3_azz_reg <= sq_tag[SQ_TAG_W-1];
        s3_nz_reg  <= sqr_nz;
    end

    logic signed [CW-1:0] az_re;
    logic signed [CW-1:0] az_im;
    logic signed [CW-1:0] el_re;
    logic signed [CW-1:0] el_im;
    logic [16:0]          rng17;

    assign az_re = {{(CW-30){s3_pt_reg.y_mm[19]}}, s3_pt_reg.y_mm, 10'b0};
    assign az_im = {{(CW-30){s3_pt_reg.x_mm[19]}}, s3_pt_reg.x_mm, 10'b0};
    assign el_re = {{(CW-N){1'b0}}, s3_h_reg};
    assign el_im = {{(CW-28){s3_pt_reg.z_mm[19]}}, s3_pt_reg.z_mm, 8'b0};
    assign rng17 = rmul_reg[lprp_pkg::DIV10_K +: 17];

    // ---------------- CORDIC pair ----------------
    logic                  az_vld;
    logic signed [AGW-1:0] az_ang;
    logic [1:0]            az_tag;
    logic                  el_vld;
    logic signed [AGW-1:0] el_ang;
    logic [16:0]           el_tag;

    lprp_cordic_pipe #(
        .W     (CW),
        .LIM   (lprp_pkg::ANG_PI),
        .TAG_W (2)
    ) u_cordic_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .re_in     (az_re),
        .im_in     (az_im),
        .in_tag    ({s3_nz_reg, s3_azz_reg}),
        .out_valid (az_vld),
        .angle     (az_ang),
        .out_tag   (az_tag)
    );

    lprp_cordic_pipe #(
        .W     (CW),
        .LIM   (lprp_pkg::ANG_HALF_PI),
        .TAG_W (17)
    ) u_cordic_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .re_in     (el_re),
        .im_in     (el_im),
        .in_tag    (rng17),
        .out_valid (el_vld),
        .angle     (el_ang),
        .out_tag   (el_tag)
    );

    // ---------------- window test, column numerator ----------------
    logic signed [AGW-1:0] az_eff;
    logic [AGW-1:0]        az_off;
    logic signed [AGW-1:0] min17;
    logic signed [AGW-1:0] max17;
    logic                  in_window;
    logic signed [AGW-1:0] num_s;
    logic signed [AGW-1:0] den_s;

    assign az_eff    = az_tag[0] ? '0 : az_ang;
    assign az_off    = AGW'(az_eff + AGW'(lprp_pkg::ANG_PI));
    assign min17     = AGW'(min_el_reg);
    assign max17     = AGW'(max_el_reg);
    assign in_window = (el_ang >= min17) && (el_ang <= max17);
    assign num_s     = max17 - el_ang;
    assign den_s     = max17 - min17;

    logic              p1_vld_reg;
    logic [NUM_W-1:0]  p1_num_reg;
    logic [NUM_W-1:0]  p1_den_reg;
    logic [COL_VW-1:0] p1_colv_reg;
    logic [15:0]       p1_rng_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p1_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= az_vld && el_vld && az_tag[1] && in_window;
        end
    end

    always_ff @(posedge clk) begin
        p1_num_reg  <= NUM_W'(num_s);
        p1_den_reg  <= NUM_W'(den_s);
        p1_colv_reg <= COL_VW'(az_off) * COL_VW'(IMAGE_WIDTH - 1)
                       + COL_VW'(lprp_pkg::ANG_PI);
        p1_rng_reg  <= el_tag[16] ? 16'hFFFF : el_tag[15:0];
    end

    // ---------------- column reciprocal, row dividend ----------------
    logic                     p2_vld_reg;
    logic [COL_VW+COL_MW-1:0] p2_colm_reg;
    logic [DVD_W-1:0]         p2_dvd_reg;
    logic [DVS_W-1:0]         p2_dvs_reg;
    logic                     p2_den0_reg;
    logic [15:0]              p2_rng_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p2_vld_reg <= 1'b0;
        end else begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        p2_colm_reg <= (COL_VW+COL_MW)'(p1_colv_reg)
                       * (COL_VW+COL_MW)'(COL_M[COL_MW-1:0]);
        p2_dvd_reg  <= DVD_W'(p1_num_reg) * DVD_W'(ROW_MC) + DVD_W'(p1_den_reg);
        p2_dvs_reg  <= {p1_den_reg, 1'b0};
        p2_den0_reg <= (p1_den_reg == '0);
        p2_rng_reg  <= p1_rng_reg;
    end

    // ---------------- row divider ----------------
    localparam int DV_TAG_W = COL_QW + 1 + 16;

    logic [COL_QW-1:0]   col_q;
    logic                dv_vld;
    logic [ROW_QW-1:0]   row_q;
    logic [DV_TAG_W-1:0] dv_tag;

    assign col_q = p2_colm_reg[COL_K +: COL_QW];

    lprp_div_pipe #(
        .QW    (ROW_QW),
        .NW    (DVD_W),
        .DW    (DVS_W),
        .TAG_W (DV_TAG_W)
    ) u_div_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_vld_reg),
        .dividend  (p2_dvd_reg),
        .divisor   (p2_dvs_reg),
        .in_tag    ({col_q, p2_den0_reg, p2_rng_reg}),
        .out_valid (dv_vld),
        .quotient  (row_q),
        .out_tag   (dv_tag)
    );

    // ---------------- output register ----------------
    logic             out_vld_reg;
    lprp_pkg::pixel_t out_pix_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= dv_vld;
        end
    end

    // equal window bounds: the only elevation inside maps to row zero
    always_ff @(posedge clk) begin
        out_pix_reg.column   <= 10'(dv_tag[DV_TAG_W-1 -: COL_QW]);
        out_pix_reg.row      <= dv_tag[16] ? 6'd0 : 6'(row_q);
        out_pix_reg.range_cm <= dv_tag[15:0];
    end

    assign result_valid = out_vld_reg;
    assign result       = out_pix_reg;

    // ---------------- assertions ----------------
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg |-> (p1_num_reg <= p1_den_reg))
        else $error("in-window item with numerator above denominator");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (IMAGE_WIDTH > 1024 || int'(result.column) <= IMAGE_WIDTH - 1))
        else $error("column beyond image width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (IMAGE_HEIGHT > 64 || int'(result.row) <= IMAGE_HEIGHT - 1))
        else $error("row beyond image height");

    a_pair_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld == sqr_vld) && (az_vld == el_vld))
        else $error("parallel pipes out of step");

endmodule
